FILE: rtl/nsrc_pkg.sv
// Shared types, codes and defaults for the notify send/retry controller.
package nsrc_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int MSG_W   = 16;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 20;
  localparam int RETRY_W = 4;
  localparam int QCNT_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DELAY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 2'd3;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST      = 4'd3;
  localparam logic [DELAY_W-1:0] RETRY_DELAY_RST      = 20'd1000;
  localparam logic [DELAY_W-1:0] QUEUE_DELAY_RST      = 20'd1000;
  localparam logic [DELAY_W-1:0] RESPONSE_TIMEOUT_RST = 20'd5000;

  // Request types
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_LOOP    = 1'b1;

  // Response line kinds
  typedef enum logic [1:0] {
    LINE_NONE   = 2'd0,
    LINE_OK     = 2'd1,
    LINE_STATUS = 2'd2,
    LINE_TEXT   = 2'd3
  } line_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONNECT = 3'd1,
    PH_SEND    = 3'd2,
    PH_WAIT    = 3'd3,
    PH_SUCCESS = 3'd4,
    PH_ERROR   = 3'd5,
    PH_RETRY   = 3'd6,
    PH_QDELAY  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [RETRY_W-1:0] retry_limit;
    logic [DELAY_W-1:0] retry_wait_ms;
    logic [DELAY_W-1:0] msg_gap_ms;
    logic [DELAY_W-1:0] response_timeout_ms;
  } cfg_t;

  // Queue status seen by the phase machine and the result register
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [MSG_W-1:0]  head;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Per-step strobes from the phase machine
  typedef struct packed {
    logic pop;
    logic send_request;
    logic close_link;
  } fsm_ctl_t;

endpackage

FILE: rtl/notify_send_retry_controller.sv
// Top level: handshake, configuration registers, queue, phase machine, result register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall | req_type msg_id now_ms connect_ok line_kind
//  out_    | output    | out_valid/out_stall | accepted phase send_request send_msg_id
//          |           |                   | close_link retry_count queue_count
//  cfg_    | input     | cfg_we            | cfg_index cfg_wdata
//
// One item per cycle while in_stall is low: each accepted item updates the queue
// and phase state at the accepting edge and its result appears in the output
// register the next cycle. The queue head comes from a RAM read of the next head
// address, so back-to-back pops and pushes into an empty queue need no wait.
// in_stall rises only while a result sits in the output register and out_stall is high.
// Synchronous active-low reset; no clearing pass, the queue store is not initialized.
module notify_send_retry_controller #(
  parameter int QUEUE_DEPTH = nsrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [nsrc_pkg::MSG_W-1:0]     in_msg_id,
  input  logic [nsrc_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                           in_connect_ok,
  input  logic [1:0]                     in_line_kind,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [2:0]                     out_phase,
  output logic                           out_send_request,
  output logic [nsrc_pkg::MSG_W-1:0]     out_send_msg_id,
  output logic                           out_close_link,
  output logic [nsrc_pkg::RETRY_W-1:0]   out_retry_count,
  output logic [nsrc_pkg::QCNT_W-1:0]    out_queue_count,
  input  logic                           cfg_we,
  input  logic [nsrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nsrc_pkg::DELAY_W-1:0]   cfg_wdata
);
  import nsrc_pkg::*;

  cfg_t               cfg_r;
  logic               accept;
  logic               push;
  logic               step_en;
  q_stat_t            qs;
  phase_t             phase_nxt;
  logic [MSG_W-1:0]   cur_id_nxt;
  logic [RETRY_W-1:0] retries_nxt;
  fsm_ctl_t           ctl;
  logic [QCNT_W-1:0]  qcount_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               accepted_r;
  logic [2:0]         phase_out_r;
  logic               send_req_r;
  logic [MSG_W-1:0]   send_id_r;
  logic               close_r;
  logic [RETRY_W-1:0] retry_r;
  logic [QCNT_W-1:0]  qcount_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit         <= RETRY_LIMIT_RST;
      cfg_r.retry_wait_ms       <= RETRY_DELAY_RST;
      cfg_r.msg_gap_ms          <= QUEUE_DELAY_RST;
      cfg_r.response_timeout_ms <= RESPONSE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:      cfg_r.retry_limit         <= cfg_wdata[RETRY_W-1:0];
        CFG_RETRY_DELAY:      cfg_r.retry_wait_ms       <= cfg_wdata;
        CFG_QUEUE_DELAY:      cfg_r.msg_gap_ms          <= cfg_wdata;
        CFG_RESPONSE_TIMEOUT: cfg_r.response_timeout_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_req_type == REQ_ENQUEUE) && !qs.full;
  assign step_en  = accept && (in_req_type == REQ_LOOP);

  nsrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_msg_id),
    .pop       (ctl.pop),
    .stat      (qs)
  );

  nsrc_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .now_ms      (in_now_ms),
    .connect_ok  (in_connect_ok),
    .line_kind   (in_line_kind),
    .cfg         (cfg_r),
    .qs          (qs),
    .phase_nxt   (phase_nxt),
    .cur_id_nxt  (cur_id_nxt),
    .retries_nxt (retries_nxt),
    .ctl         (ctl)
  );

  // Count after this item; push and pop never happen on the same item
  always_comb begin
    priority if (push) begin
      qcount_nxt = qs.count + 1'b1;
    end else if (ctl.pop) begin
      qcount_nxt = qs.count - 1'b1;
    end else begin
      qcount_nxt = qs.count;
    end
  end

  // Result register
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      accepted_r  <= push;
      phase_out_r <= 3'(phase_nxt);
      send_req_r  <= ctl.send_request;
      send_id_r   <= cur_id_nxt;
      close_r     <= ctl.close_link;
      retry_r     <= retries_nxt;
      qcount_r    <= qcount_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = accepted_r;
  assign out_phase        = phase_out_r;
  assign out_send_request = send_req_r;
  assign out_send_msg_id  = send_id_r;
  assign out_close_link   = close_r;
  assign out_retry_count  = retry_r;
  assign out_queue_count  = qcount_r;

  // A request goes out only on the step that enters the wait phase
  a_send_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.send_request |=> out_phase == 3'(PH_WAIT))
    else $error("send_request without entering wait phase");

  // Closing the link always lands in retry wait or queue delay
  a_close_target: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.close_link |=>
      (out_phase == 3'(PH_RETRY)) || (out_phase == 3'(PH_QDELAY)))
    else $error("close_link with unexpected next phase");

  // The queue is never pushed when full nor popped when empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qs.full) && !(ctl.pop && qs.empty))
    else $error("queue overflow or underflow");

  // A pop is only taken by a loop-pass item and starts a connect
  a_pop_connect: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> step_en && (phase_nxt == PH_CONNECT) && !push)
    else $error("pop outside idle-to-connect step");

endmodule

FILE: rtl/nsrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nsrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/nsrc_queue.sv
// Circular message queue: pointers, fill count, store and head bypass.
module nsrc_queue #(
  parameter int DEPTH = nsrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [nsrc_pkg::MSG_W-1:0] push_data,
  input  logic                   pop,
  output nsrc_pkg::q_stat_t      stat
);
  import nsrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             byp_v_r, byp_v_nxt;
  logic [MSG_W-1:0] byp_data_r;
  logic [MSG_W-1:0] ram_rdata;
  logic [CNT_W+QCNT_W-1:0] cnt_ext;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // The RAM reads the next head address; a write landing on that address in the
  // same cycle returns old data, so the new word is held aside.
  assign byp_v_nxt = push && (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      byp_v_r  <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      byp_v_r  <= byp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byp_v_nxt) begin
      byp_data_r <= push_data;
    end
  end

  nsrc_ram #(
    .WIDTH (MSG_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  assign cnt_ext = {{QCNT_W{1'b0}}, cnt_r};

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.head  = byp_v_r ? byp_data_r : ram_rdata;
  assign stat.count = cnt_ext[QCNT_W-1:0];

endmodule

FILE: rtl/nsrc_fsm.sv
// Eight-phase connect/send/retry machine with current-message registers.
module nsrc_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [nsrc_pkg::TIME_W-1:0] now_ms,
  input  logic                        connect_ok,
  input  logic [1:0]                  line_kind,
  input  nsrc_pkg::cfg_t              cfg,
  input  nsrc_pkg::q_stat_t           qs,
  output nsrc_pkg::phase_t            phase_nxt,
  output logic [nsrc_pkg::MSG_W-1:0]  cur_id_nxt,
  output logic [nsrc_pkg::RETRY_W-1:0] retries_nxt,
  output nsrc_pkg::fsm_ctl_t          ctl
);
  import nsrc_pkg::*;

  phase_t             phase_r;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [MSG_W-1:0]   cur_id_r;
  logic [RETRY_W-1:0] retries_r;
  logic               has_cur_r, has_cur_nxt;
  logic               req_sent_r, req_sent_nxt;
  logic [TIME_W-1:0]  elapsed;
  logic               can_retry;
  line_kind_t         line;

  assign elapsed   = now_ms - start_r;
  assign can_retry = has_cur_r && (retries_r < cfg.retry_limit);
  assign line      = line_kind_t'(line_kind);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step_en) begin
      unique case (phase_r)
        PH_IDLE:    if (!has_cur_r && !qs.empty) phase_nxt = PH_CONNECT;
        PH_CONNECT: phase_nxt = connect_ok ? PH_SEND : PH_ERROR;
        PH_SEND:    if (!req_sent_r) phase_nxt = PH_WAIT;
        PH_WAIT: begin
          priority if (line == LINE_OK) begin
            phase_nxt = PH_SUCCESS;
          end else if (line == LINE_STATUS) begin
            phase_nxt = PH_ERROR;
          end else if (elapsed > TIME_W'(cfg.response_timeout_ms)) begin
            phase_nxt = PH_ERROR;
          end else begin
            phase_nxt = phase_r;
          end
        end
        PH_SUCCESS: phase_nxt = PH_QDELAY;
        PH_ERROR:   phase_nxt = can_retry ? PH_RETRY : PH_QDELAY;
        PH_RETRY:   if (elapsed >= TIME_W'(cfg.retry_wait_ms)) phase_nxt = PH_CONNECT;
        PH_QDELAY:  if (elapsed >= TIME_W'(cfg.msg_gap_ms)) phase_nxt = PH_IDLE;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  // Strobes and per-message registers
  always_comb begin
    ctl          = '0;
    cur_id_nxt   = cur_id_r;
    retries_nxt  = retries_r;
    has_cur_nxt  = has_cur_r;
    req_sent_nxt = req_sent_r;
    if (step_en) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (!has_cur_r && !qs.empty) begin
            ctl.pop     = 1'b1;
            cur_id_nxt  = qs.head;
            retries_nxt = '0;
            has_cur_nxt = 1'b1;
          end
        end
        PH_SEND: begin
          if (!req_sent_r) begin
            ctl.send_request = 1'b1;
            req_sent_nxt     = 1'b1;
          end
        end
        PH_SUCCESS: begin
          ctl.close_link = 1'b1;
          req_sent_nxt   = 1'b0;
          has_cur_nxt    = 1'b0;
        end
        PH_ERROR: begin
          ctl.close_link = 1'b1;
          req_sent_nxt   = 1'b0;
          if (can_retry) begin
            retries_nxt = retries_r + 1'b1;
          end else begin
            has_cur_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Every phase change restarts the phase timer
  assign start_nxt = (phase_nxt != phase_r) ? now_ms : start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      start_r    <= '0;
      cur_id_r   <= '0;
      retries_r  <= '0;
      has_cur_r  <= 1'b0;
      req_sent_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      start_r    <= start_nxt;
      cur_id_r   <= cur_id_nxt;
      retries_r  <= retries_nxt;
      has_cur_r  <= has_cur_nxt;
      req_sent_r <= req_sent_nxt;
    end
  end

endmodule
